@@ rtl/tsob_pkg.sv @@
// ============================================================================
// tsob_pkg: shared types and codes for the TSO store buffer
// Request and result payloads, request and status codes, cell controls.
// ============================================================================
package tsob_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int DATA_BYTES_DEF = 8;

    // request codes
    localparam logic [2:0] RT_STORE  = 3'd0;
    localparam logic [2:0] RT_LOAD   = 3'd1;
    localparam logic [2:0] RT_FENCE  = 3'd2;
    localparam logic [2:0] RT_DRAIN  = 3'd3;
    localparam logic [2:0] RT_ATOMIC = 3'd4;

    // status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FORWARD = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_WRITE   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] req_addr;
        logic [3:0]  req_size;
        logic [63:0] req_data;
    } tsob_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_addr;
        logic [3:0]  out_size;
        logic [63:0] out_data;
        logic        resume;
        logic        now_empty;
    } tsob_rsp_t;

    typedef struct packed {
        logic live;   // entry lies below the fill count
        logic load;   // take the incoming store
        logic shift;  // take the younger neighbour's entry
    } tsob_cell_ctrl_t;

endpackage

@@ rtl/tso_store_buffer_forwarding_core.sv @@
// ============================================================================
// tso_store_buffer_forwarding_core: TSO store buffer with load forwarding
// FIFO of pending stores in a row of cells; loads forward from the youngest
// overlap if it is exact; drains retire the oldest entry as a memory write.
// ============================================================================
//  channel   | signals            | transfer
//  ----------+--------------------+---------------------------------------
//  request   | start, busy, req   | edge with start high and busy low
//  result    | done, result       | edge ending the single cycle done is high
//
//  Each item passes through accept, compare in every cell, pick of the
//  youngest overlapping cell, then update and result, in that order. A new
//  request is taken in the cycle its predecessor's result is shown. Reset
//  empties the buffer and clears the wait mark at once. The receiver cannot
//  stall; each result is shown for one cycle.
// ============================================================================
module tso_store_buffer_forwarding_core
    import tsob_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int DATA_BYTES = DATA_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tsob_req_t req,
    output logic      done,
    output tsob_rsp_t result
);

    localparam int DB_W  = DATA_BYTES * 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [2:0]           type_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [3:0]           size_reg;
    logic [DB_W-1:0]      data_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 wait_vld_reg;
    logic                 wait_vld_next;
    logic [CNT_W-1:0]     wait_val_reg;
    logic [CNT_W-1:0]     wait_val_next;
    logic                 done_reg;
    tsob_rsp_t            result_reg;
    tsob_rsp_t            result_next;

    logic                 accept;
    logic [3:0]           size_c;
    logic [DB_W-1:0]      mask_c;
    logic                 do_store;
    logic                 do_shift;
    logic [CNT_W-1:0]     cnt_dec;

    logic [ADDR_BITS-1:0] cell_addr [DEPTH];
    logic [3:0]           cell_size [DEPTH];
    logic [DB_W-1:0]      cell_data [DEPTH];
    logic [DEPTH-1:0]     cell_ovl;
    logic [DEPTH-1:0]     cell_exact;
    logic                 hit_any;
    logic                 hit_exact;
    logic [IDX_W-1:0]     hit_idx;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // clamp size and mask data to that many bytes
    always_comb
    begin
        if (req.req_size == 4'd0)
            size_c = 4'd1;
        else if (req.req_size > 4'(DATA_BYTES))
            size_c = 4'(DATA_BYTES);
        else
            size_c = req.req_size;
        for (int b = 0; b < DB_W; b++)
            mask_c[b] = (4'(b >> 3) < size_c);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            addr_reg <= ADDR_BITS'(req.req_addr);
            size_reg <= size_c;
            data_reg <= DB_W'(req.req_data) & mask_c;
        end
    end

    assign do_store = (state_reg == S_EXEC) && (type_reg == RT_STORE) &&
                      (count_reg < CNT_W'(DEPTH));
    assign do_shift = (state_reg == S_EXEC) && (type_reg == RT_DRAIN) &&
                      (count_reg != '0);
    assign cnt_dec  = count_reg - 1'b1;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tsob_cell_ctrl_t      ctrl;
        logic [ADDR_BITS-1:0] nb_addr;
        logic [3:0]           nb_size;
        logic [DB_W-1:0]      nb_data;

        assign ctrl.live  = (CNT_W'(i) < count_reg);
        assign ctrl.load  = do_store && (count_reg == CNT_W'(i));
        assign ctrl.shift = do_shift;

        if (i < DEPTH - 1)
        begin : g_nb
            assign nb_addr = cell_addr[i+1];
            assign nb_size = cell_size[i+1];
            assign nb_data = cell_data[i+1];
        end
        else
        begin : g_end
            assign nb_addr = '0;
            assign nb_size = '0;
            assign nb_data = '0;
        end

        tsob_cell #(
            .ADDR_BITS  (ADDR_BITS),
            .DATA_BYTES (DATA_BYTES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .req_addr (addr_reg),
            .req_size (size_reg),
            .req_data (data_reg),
            .nb_addr  (nb_addr),
            .nb_size  (nb_size),
            .nb_data  (nb_data),
            .addr     (cell_addr[i]),
            .size     (cell_size[i]),
            .data     (cell_data[i]),
            .ovl      (cell_ovl[i]),
            .exact    (cell_exact[i])
        );
    end

    tsob_pick #(
        .DEPTH (DEPTH)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ovl       (cell_ovl),
        .exact     (cell_exact),
        .hit_any   (hit_any),
        .hit_exact (hit_exact),
        .hit_idx   (hit_idx)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        wait_vld_next = wait_vld_reg;
        wait_val_next = wait_val_reg;
        result_next   = '0;
        result_next.status = ST_REFUSED;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (type_reg)
                    RT_STORE:
                    begin
                        if (do_store)
                        begin
                            count_next         = count_reg + 1'b1;
                            result_next.status = ST_STORED;
                        end
                        else
                        begin
                            result_next.status = ST_FULL;
                        end
                    end
                    RT_LOAD:
                    begin
                        if (hit_any && !hit_exact)
                        begin
                            result_next.status = ST_REFUSED;
                            wait_vld_next      = 1'b1;
                            wait_val_next      = count_reg - CNT_W'(hit_idx) - 1'b1;
                        end
                        else
                        begin
                            result_next.status   = hit_any ? ST_FORWARD : ST_READ;
                            result_next.out_addr = 32'(addr_reg);
                            result_next.out_size = size_reg;
                            if (hit_any)
                                result_next.out_data = 64'(cell_data[hit_idx]);
                        end
                    end
                    RT_FENCE, RT_ATOMIC:
                    begin
                        if (count_reg != '0)
                        begin
                            result_next.status = ST_REFUSED;
                            wait_vld_next      = 1'b1;
                            wait_val_next      = '0;
                        end
                        else if (type_reg == RT_ATOMIC)
                        begin
                            result_next.status   = ST_WRITE;
                            result_next.out_addr = 32'(addr_reg);
                            result_next.out_size = size_reg;
                            result_next.out_data = 64'(data_reg);
                        end
                        else
                        begin
                            result_next.status = ST_STORED;
                        end
                    end
                    RT_DRAIN:
                    begin
                        if (do_shift)
                        begin
                            count_next           = cnt_dec;
                            result_next.status   = ST_WRITE;
                            result_next.out_addr = 32'(cell_addr[0]);
                            result_next.out_size = cell_size[0];
                            result_next.out_data = 64'(cell_data[0]);
                            result_next.now_empty = (cnt_dec == '0);
                            if (wait_vld_reg && (cnt_dec <= wait_val_reg))
                            begin
                                result_next.resume = 1'b1;
                                wait_vld_next      = 1'b0;
                            end
                        end
                        else
                        begin
                            result_next.status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        result_next.status = ST_REFUSED;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wait_vld_reg <= 1'b0;
            wait_val_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wait_vld_reg <= wait_vld_next;
            wait_val_reg <= wait_val_next;
            done_reg     <= (state_reg == S_EXEC);
        end
    end

    // hold the last result; the strobe marks the single valid cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_wait_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        wait_vld_reg |-> (wait_val_reg < count_reg))
        else $error("wait mark not below fill count");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an item finishing");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.now_empty) |-> (count_reg == '0))
        else $error("empty flag with entries left");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done_reg))
        else $error("not busy after accepting a request");

endmodule

@@ rtl/tsob_cell.sv @@
// ============================================================================
// tsob_cell: one store buffer entry
// Holds address, size and data of one pending store, hands it to the older
// neighbour on a drain and registers its overlap and exact-match flags.
// ============================================================================
module tsob_cell
    import tsob_pkg::*;
#(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int DATA_BYTES = DATA_BYTES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tsob_cell_ctrl_t           ctrl,
    input  logic [ADDR_BITS-1:0]      req_addr,
    input  logic [3:0]                req_size,
    input  logic [DATA_BYTES*8-1:0]   req_data,
    input  logic [ADDR_BITS-1:0]      nb_addr,
    input  logic [3:0]                nb_size,
    input  logic [DATA_BYTES*8-1:0]   nb_data,
    output logic [ADDR_BITS-1:0]      addr,
    output logic [3:0]                size,
    output logic [DATA_BYTES*8-1:0]   data,
    output logic                      ovl,
    output logic                      exact
);

    logic [ADDR_BITS-1:0]    addr_reg;
    logic [3:0]              size_reg;
    logic [DATA_BYTES*8-1:0] data_reg;
    logic                    ovl_reg;
    logic                    ovl_next;
    logic                    exact_reg;
    logic                    exact_next;
    logic [ADDR_BITS-1:0]    diff_er;
    logic [ADDR_BITS-1:0]    diff_re;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            addr_reg <= req_addr;
            size_reg <= req_size;
            data_reg <= req_data;
        end
        else if (ctrl.shift)
        begin
            addr_reg <= nb_addr;
            size_reg <= nb_size;
            data_reg <= nb_data;
        end
    end

    // overlap test wraps modulo the address space
    always_comb
    begin
        diff_er    = addr_reg - req_addr;
        diff_re    = req_addr - addr_reg;
        ovl_next   = ctrl.live && ((diff_er < ADDR_BITS'(req_size)) ||
                                   (diff_re < ADDR_BITS'(size_reg)));
        exact_next = (addr_reg == req_addr) && (size_reg == req_size);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg   <= 1'b0;
            exact_reg <= 1'b0;
        end
        else
        begin
            ovl_reg   <= ovl_next;
            exact_reg <= exact_next;
        end
    end

    assign addr  = addr_reg;
    assign size  = size_reg;
    assign data  = data_reg;
    assign ovl   = ovl_reg;
    assign exact = exact_reg;

endmodule

@@ rtl/tsob_pick.sv @@
// ============================================================================
// tsob_pick: youngest overlapping entry
// Registered priority pick over the cell flags, highest index wins.
// ============================================================================
module tsob_pick
    import tsob_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DEPTH-1:0]  ovl,
    input  logic [DEPTH-1:0]  exact,
    output logic              hit_any,
    output logic              hit_exact,
    output logic [IDX_W-1:0]  hit_idx
);

    logic             any_reg;
    logic             any_next;
    logic             exact_reg;
    logic             exact_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        any_next   = 1'b0;
        exact_next = 1'b0;
        idx_next   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ovl[i])
            begin
                any_next   = 1'b1;
                exact_next = exact[i];
                idx_next   = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg   <= 1'b0;
            exact_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            any_reg   <= any_next;
            exact_reg <= exact_next;
            idx_reg   <= idx_next;
        end
    end

    assign hit_any   = any_reg;
    assign hit_exact = exact_reg;
    assign hit_idx   = idx_reg;

endmodule
